// ===== src/ghash_pkg.sv =====
// Shared types and constants of the GHASH accumulate and tag unit.
package ghash_pkg;

  localparam int unsigned BLOCK_BYTES   = 16;
  localparam int unsigned BLOCK_BITS    = 128;
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned LEN_BITS      = 61;
  localparam int unsigned VBYTES_BITS   = 5;

  // item kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // configuration register indexes
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  typedef logic [BLOCK_BITS-1:0] blk_t;

  typedef struct packed {
    logic                   kind;
    logic [WORD_BITS-1:0]   block_high;
    logic [WORD_BITS-1:0]   block_low;
    logic [VBYTES_BITS-1:0] valid_bytes;
    logic [LEN_BITS-1:0]    aad_bytes;
    logic [LEN_BITS-1:0]    ct_bytes;
  } item_t;

endpackage

// ===== src/ghash_in_if.sv =====
// Input channel: data or final length beats with valid/ready handshake.
interface ghash_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [ghash_pkg::WORD_BITS-1:0]     block_high;
  logic [ghash_pkg::WORD_BITS-1:0]     block_low;
  logic [ghash_pkg::VBYTES_BITS-1:0]   valid_bytes;
  logic [ghash_pkg::LEN_BITS-1:0]      aad_bytes;
  logic [ghash_pkg::LEN_BITS-1:0]      ct_bytes;

  modport source (output valid, kind, block_high, block_low, valid_bytes, aad_bytes,
                  ct_bytes, input ready);
  modport sink   (input valid, kind, block_high, block_low, valid_bytes, aad_bytes,
                  ct_bytes, output ready);
endinterface

// ===== src/ghash_out_if.sv =====
// Result channel: updated accumulator or tag beats with valid/ready handshake.
interface ghash_out_if;
  logic                            valid;
  logic                            ready;
  logic [ghash_pkg::WORD_BITS-1:0] digest_high;
  logic [ghash_pkg::WORD_BITS-1:0] digest_low;
  logic                            is_tag;

  modport source (output valid, digest_high, digest_low, is_tag, input ready);
  modport sink   (input valid, digest_high, digest_low, is_tag, output ready);
endinterface

// ===== src/ghash_blk_fmt.sv =====
// Builds the 128-bit block to fold in: zero-padded data or the length block.
module ghash_blk_fmt (
  input  ghash_pkg::item_t item,
  output ghash_pkg::blk_t  blk
);

  logic [ghash_pkg::VBYTES_BITS-1:0] nbytes;
  ghash_pkg::blk_t                   mask;
  ghash_pkg::blk_t                   data;

  // counts above sixteen take the whole block
  assign nbytes = (item.valid_bytes > ghash_pkg::VBYTES_BITS'(ghash_pkg::BLOCK_BYTES))
                  ? ghash_pkg::VBYTES_BITS'(ghash_pkg::BLOCK_BYTES) : item.valid_bytes;

  always_comb begin
    for (int b = 0; b < ghash_pkg::BLOCK_BYTES; b++) begin
      // byte 0 sits in the top byte lane
      mask[ghash_pkg::BLOCK_BITS-1-8*b -: 8] =
        {8{ghash_pkg::VBYTES_BITS'(b) < nbytes}};
    end
  end

  assign data = {item.block_high, item.block_low} & mask;

  always_comb begin
    if (item.kind == ghash_pkg::KIND_FINAL) begin
      blk = {item.aad_bytes, 3'b000, item.ct_bytes, 3'b000};
    end else begin
      blk = data;
    end
  end

endmodule

// ===== src/ghash_gf_mul.sv =====
// GF(2^128) multiplier in GCM bit order: carry-less product then fixed reduction.
module ghash_gf_mul (
  input  ghash_pkg::blk_t x,
  input  ghash_pkg::blk_t h,
  output ghash_pkg::blk_t z
);

  localparam int unsigned NB = ghash_pkg::BLOCK_BITS;

  function automatic ghash_pkg::blk_t bit_rev(input ghash_pkg::blk_t v);
    ghash_pkg::blk_t r;
    for (int k = 0; k < NB; k++) begin
      r[k] = v[NB-1-k];
    end
    return r;
  endfunction

  ghash_pkg::blk_t  xa;
  ghash_pkg::blk_t  ha;
  logic [2*NB-2:0]  prod;
  logic [NB-2:0]    hi;
  logic [NB+6:0]    fold1;
  logic [5:0]       ovf;
  ghash_pkg::blk_t  red;

  // coefficient of x^k lives in bit k after reversal
  assign xa = bit_rev(x);
  assign ha = bit_rev(h);

  // XOR of 128 independent shifted partial products
  always_comb begin
    prod = '0;
    for (int i = 0; i < NB; i++) begin
      if (xa[i]) begin
        prod = prod ^ ({{(NB-1){1'b0}}, ha} << i);
      end
    end
  end

  // x^128 = x^7 + x^2 + x + 1, applied twice to catch the spill above bit 127
  assign hi    = prod[2*NB-2:NB];
  assign fold1 = {7'b0, prod[NB-1:0]} ^ {8'b0, hi} ^ {7'b0, hi, 1'b0}
               ^ {6'b0, hi, 2'b0} ^ {1'b0, hi, 7'b0};
  assign ovf   = fold1[NB+5:NB];
  assign red   = fold1[NB-1:0] ^ {{(NB-6){1'b0}}, ovf} ^ {{(NB-7){1'b0}}, ovf, 1'b0}
               ^ {{(NB-8){1'b0}}, ovf, 2'b0} ^ {{(NB-13){1'b0}}, ovf, 7'b0};

  assign z = bit_rev(red);

endmodule

// ===== src/ghash_accumulate_and_tag_unit.sv =====
// Top level of the GHASH accumulate and tag unit.
//
//  channel  | dir | handshake      | beat contents
//  ---------+-----+----------------+---------------------------------------------
//  in_ch    | in  | valid/ready    | kind, block_high/low, valid_bytes, aad/ct_bytes
//  out_ch   | out | valid/ready    | digest_high, digest_low, is_tag
//  cfg_*    | in  | we, no wait    | key_high (index 0), key_low (index 1)
//
// One beat per cycle sustained while the result channel is ready; each beat is
// held in the input register, then its result in the output register. The
// combinational GF(2^128) multiplier feeds the accumulator register, so each beat sees the previous beat's accumulator.
// Synchronous reset clears the key, the accumulator and both stage valids.
// A stalled result holds the output register; the input register still takes a
// beat while it is empty.
module ghash_accumulate_and_tag_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  ghash_in_if.sink                         in_ch,
  ghash_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [ghash_pkg::WORD_BITS-1:0]  cfg_wdata
);

  logic [ghash_pkg::WORD_BITS-1:0] key_high_r;
  logic [ghash_pkg::WORD_BITS-1:0] key_low_r;
  ghash_pkg::blk_t                 acc_r;
  ghash_pkg::blk_t                 acc_nxt;

  logic                            in_v_r;
  ghash_pkg::item_t                item_r;
  ghash_pkg::item_t                item_in;

  logic                            out_v_r;
  ghash_pkg::blk_t                 digest_r;
  logic                            is_tag_r;

  ghash_pkg::blk_t                 blk;
  ghash_pkg::blk_t                 prod;
  logic                            adv;

  assign item_in = '{kind:        in_ch.kind,
                     block_high:  in_ch.block_high,
                     block_low:   in_ch.block_low,
                     valid_bytes: in_ch.valid_bytes,
                     aad_bytes:   in_ch.aad_bytes,
                     ct_bytes:    in_ch.ct_bytes};

  // the multiply stage moves when the result register is free or being drained
  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == ghash_pkg::CFG_KEY_HIGH) begin
        key_high_r <= cfg_wdata;
      end else begin
        key_low_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r <= item_in;
    end
  end

  ghash_blk_fmt u_fmt (
    .item (item_r),
    .blk  (blk)
  );

  ghash_gf_mul u_mul (
    .x (acc_r ^ blk),
    .h ({key_high_r, key_low_r}),
    .z (prod)
  );

  always_comb begin
    if (item_r.kind == ghash_pkg::KIND_FINAL) begin
      acc_nxt = '0;
    end else begin
      acc_nxt = prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (adv) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      digest_r <= prod;
      is_tag_r <= item_r.kind;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.digest_high = digest_r[ghash_pkg::BLOCK_BITS-1:ghash_pkg::WORD_BITS];
  assign out_ch.digest_low  = digest_r[ghash_pkg::WORD_BITS-1:0];
  assign out_ch.is_tag      = is_tag_r;

  // a tag beat leaves the accumulator clear for the next message
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item_r.kind == ghash_pkg::KIND_FINAL |=> acc_r == '0)
    else $error("accumulator not cleared after tag");

  // a beat waiting in the input register is not lost or altered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(item_r))
    else $error("input stage dropped a stalled beat");

  // every stage move lands a result carrying its kind
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r && is_tag_r == $past(item_r.kind))
    else $error("result register missed a beat");

endmodule
